// ----- hw/rtl/m4i_pkg.sv -----
// Shared widths, term tables and types for the 4x4 matrix inverse.
package m4i_pkg;

   localparam int ELEM_W = 32;
   localparam int COF_W  = 97;
   localparam int DET_W  = 131;
   localparam int MOP_W  = 33;
   localparam int PROD_W = 66;

   localparam logic [ELEM_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [ELEM_W-1:0] SAT_MIN = 32'h8000_0000;

   // column slot used by each row of the six terms of a 3x3 determinant
   localparam logic [1:0] TERM_SLOT [6][3] = '{
      '{2'd0, 2'd1, 2'd2},
      '{2'd1, 2'd2, 2'd0},
      '{2'd2, 2'd0, 2'd1},
      '{2'd2, 2'd1, 2'd0},
      '{2'd1, 2'd0, 2'd2},
      '{2'd0, 2'd2, 2'd1}
   };
   localparam logic [5:0] TERM_NEG  = 6'b111000;
   localparam logic [2:0] TERM_LAST = 3'd5;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic [1:0] skip_idx(input logic [1:0] drop, input logic [1:0] j);
      return (j >= drop) ? j + 2'd1 : j;
   endfunction

   // matrix address of row j of term t of the cofactor for adjugate entry k
   function automatic logic [3:0] term_addr(input logic [3:0] k, input logic [2:0] t,
                                            input logic [1:0] j);
      logic [1:0] row;
      logic [1:0] col;
      row = skip_idx(k[3:2], j);
      col = skip_idx(k[1:0], TERM_SLOT[t][j]);
      return {col, row};
   endfunction

endpackage

// ----- hw/rtl/m4i_div.sv -----
// Bit-serial signed divider with 32-bit saturated quotient.
module m4i_div
   import m4i_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [COF_W-1:0] num,
   input  logic signed [DET_W-1:0] den,
   output div_stat_type            stat,
   output logic [ELEM_W-1:0]       quo
);

   localparam int NSH_W = COF_W + 2 * FRAC_BITS;
   localparam int WW    = (NSH_W > DET_W + ELEM_W) ? NSH_W : DET_W + ELEM_W;

   logic [WW-1:0]     rem_ff, rem_in, dsh_ff, dsh_in;
   logic [ELEM_W-1:0] q_ff, q_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic              neg_ff, neg_in, ovf_ff, ovf_in;
   logic [COF_W-1:0]  nmag;
   logic [DET_W-1:0]  dmag;
   logic              ge;

   assign nmag = num[COF_W-1] ? COF_W'(-num) : COF_W'(num);
   assign dmag = den[DET_W-1] ? DET_W'(-den) : DET_W'(den);
   assign ge   = rem_ff >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      neg_in  = neg_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         rem_in  = {{(WW-COF_W){1'b0}}, nmag} << (2 * FRAC_BITS);
         dsh_in  = {{(WW-DET_W-ELEM_W){1'b0}}, dmag, {ELEM_W{1'b0}}};
         q_in    = '0;
         cnt_in  = 6'(ELEM_W);
         busy_in = 1'b1;
         done_in = 1'b0;
         neg_in  = num[COF_W-1] ^ den[DET_W-1];
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         if (cnt_ff == 6'(ELEM_W)) begin
            ovf_in = ge;
         end else begin
            if (ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            q_in = {q_ff[ELEM_W-2:0], ge};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
   end

   always_comb begin
      if (ovf_ff) begin
         quo = neg_ff ? SAT_MIN : SAT_MAX;
      end else if (neg_ff) begin
         quo = q_ff[ELEM_W-1] ? SAT_MIN : ELEM_W'(-q_ff);
      end else begin
         quo = q_ff[ELEM_W-1] ? SAT_MAX : q_ff;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- hw/rtl/matrix4_inverse.sv -----
// 4x4 matrix inverse by adjugate over a matrix memory, cofactor memory and one multiplier.
// Load: one element per cycle while req_stall is low (in the load state), 16 elements in all.
// Cofactors: 6 terms each (states T0-T4), then CWR; determinant adds D0-D4 when k[1:0] == 0.
// Each result then goes through the bit-serial divider (33 steps).
// A new matrix is taken after the last result; singular matrices skip the divider and return their elements.
// Synchronous reset drops a partial matrix and any pending results.
module matrix4_inverse
   import m4i_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ELEM_W-1:0] req_element,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [ELEM_W-1:0] rsp_value,
   output logic [3:0]               rsp_position,
   output logic                     rsp_singular,
   output logic                     rsp_last
);

   localparam logic [4:0] ST_LOAD  = 5'd0;
   localparam logic [4:0] ST_T0    = 5'd1;
   localparam logic [4:0] ST_T1    = 5'd2;
   localparam logic [4:0] ST_T2    = 5'd3;
   localparam logic [4:0] ST_T3    = 5'd4;
   localparam logic [4:0] ST_T4    = 5'd5;
   localparam logic [4:0] ST_CWR   = 5'd6;
   localparam logic [4:0] ST_D0    = 5'd7;
   localparam logic [4:0] ST_D1    = 5'd8;
   localparam logic [4:0] ST_D2    = 5'd9;
   localparam logic [4:0] ST_D3    = 5'd10;
   localparam logic [4:0] ST_D4    = 5'd11;
   localparam logic [4:0] ST_NEXT  = 5'd12;
   localparam logic [4:0] ST_CHK   = 5'd13;
   localparam logic [4:0] ST_DVRD  = 5'd14;
   localparam logic [4:0] ST_DVGO  = 5'd15;
   localparam logic [4:0] ST_DVW   = 5'd16;
   localparam logic [4:0] ST_EMIT  = 5'd17;

   logic [ELEM_W-1:0] mat_mem [16];
   logic [COF_W-1:0]  cof_mem [16];

   logic [4:0]               state_ff, state_in;
   logic [3:0]               load_cnt_ff, load_cnt_in;
   logic [3:0]               k_ff, k_in;
   logic [2:0]               t_ff, t_in;
   logic signed [COF_W-1:0]  acc_ff, acc_in, cof_ff, cof_in;
   logic signed [DET_W-1:0]  det_ff, det_in;
   logic signed [PROD_W-1:0] mul_ff;
   logic [ELEM_W-1:0]        lo_ff, lo_in;
   logic                     sing_ff, sing_in;
   logic signed [ELEM_W-1:0] rd0_ff, rd1_ff;
   logic [COF_W-1:0]         cof_rd_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [ELEM_W-1:0] value_ff;
   logic [3:0]               pos_ff;
   logic                     rsing_ff, last_ff;

   logic [3:0]               rd_a0, rd_a1;
   logic signed [MOP_W-1:0]  ma, mb;
   logic                     cof_we, div_start, out_load, req_acc, neg_term;
   logic [ELEM_W-1:0]        div_quo;
   div_stat_type             div_stat;

   assign req_stall = (state_ff != ST_LOAD);
   assign req_acc   = req_valid && !req_stall;
   assign neg_term  = TERM_NEG[t_ff] ^ k_ff[2] ^ k_ff[0];

   m4i_div #(
      .FRAC_BITS(FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (cof_rd_ff),
      .den   (det_ff),
      .stat  (div_stat),
      .quo   (div_quo)
   );

   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      k_in        = k_ff;
      t_in        = t_ff;
      acc_in      = acc_ff;
      cof_in      = cof_ff;
      det_in      = det_ff;
      lo_in       = lo_ff;
      sing_in     = sing_ff;
      rd_a0       = k_ff;
      rd_a1       = term_addr(k_ff, t_ff, 2'd1);
      ma          = '0;
      mb          = '0;
      cof_we      = 1'b0;
      div_start   = 1'b0;
      out_load    = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               load_cnt_in = load_cnt_ff + 4'd1;
               if (load_cnt_ff == 4'd15) begin
                  state_in = ST_T0;
                  k_in     = '0;
                  t_in     = '0;
                  acc_in   = '0;
                  det_in   = '0;
               end
            end
         end
         ST_T0: begin
            rd_a0    = term_addr(k_ff, t_ff, 2'd0);
            state_in = ST_T1;
         end
         ST_T1: begin
            ma       = MOP_W'(rd0_ff);
            mb       = MOP_W'(rd1_ff);
            rd_a0    = term_addr(k_ff, t_ff, 2'd2);
            state_in = ST_T2;
         end
         ST_T2: begin
            ma       = {mul_ff[63], mul_ff[63:32]};
            mb       = MOP_W'(rd0_ff);
            rd_a0    = term_addr(k_ff, t_ff, 2'd2);
            lo_in    = mul_ff[31:0];
            state_in = ST_T3;
         end
         ST_T3: begin
            acc_in   = neg_term ? acc_ff - {mul_ff[64:0], 32'b0}
                                : acc_ff + {mul_ff[64:0], 32'b0};
            ma       = {1'b0, lo_ff};
            mb       = MOP_W'(rd0_ff);
            state_in = ST_T4;
         end
         ST_T4: begin
            acc_in = neg_term ? acc_ff - {{31{mul_ff[65]}}, mul_ff}
                              : acc_ff + {{31{mul_ff[65]}}, mul_ff};
            if (t_ff == TERM_LAST) begin
               state_in = ST_CWR;
            end else begin
               t_in     = t_ff + 3'd1;
               state_in = ST_T0;
            end
         end
         ST_CWR: begin
            cof_we   = 1'b1;
            cof_in   = acc_ff;
            state_in = (k_ff[1:0] == 2'd0) ? ST_D0 : ST_NEXT;
         end
         ST_D0: begin
            rd_a0    = {2'b00, k_ff[3:2]};
            state_in = ST_D1;
         end
         ST_D1: begin
            ma       = {1'b0, cof_ff[31:0]};
            mb       = MOP_W'(rd0_ff);
            rd_a0    = {2'b00, k_ff[3:2]};
            state_in = ST_D2;
         end
         ST_D2: begin
            det_in   = det_ff + {{65{mul_ff[65]}}, mul_ff};
            ma       = {1'b0, cof_ff[63:32]};
            mb       = MOP_W'(rd0_ff);
            rd_a0    = {2'b00, k_ff[3:2]};
            state_in = ST_D3;
         end
         ST_D3: begin
            det_in   = det_ff + {{33{mul_ff[65]}}, mul_ff, 32'b0};
            ma       = cof_ff[96:64];
            mb       = MOP_W'(rd0_ff);
            state_in = ST_D4;
         end
         ST_D4: begin
            det_in   = det_ff + {mul_ff[65], mul_ff, 64'b0};
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            acc_in = '0;
            t_in   = '0;
            if (k_ff == 4'd15) begin
               state_in = ST_CHK;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = ST_T0;
            end
         end
         ST_CHK: begin
            sing_in  = (det_ff == '0);
            k_in     = '0;
            state_in = ST_DVRD;
         end
         ST_DVRD: begin
            state_in = ST_DVGO;
         end
         ST_DVGO: begin
            rd_a0 = k_ff;
            if (sing_ff) begin
               state_in = ST_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DVW;
            end
         end
         ST_DVW: begin
            if (div_stat.done && !div_stat.busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               if (k_ff == 4'd15) begin
                  load_cnt_in = '0;
                  state_in    = ST_LOAD;
               end else begin
                  k_in     = k_ff + 4'd1;
                  state_in = ST_DVRD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         mat_mem[load_cnt_ff] <= req_element;
      end
      rd0_ff <= mat_mem[rd_a0];
      rd1_ff <= mat_mem[rd_a1];
   end

   always_ff @(posedge clock) begin
      if (cof_we) begin
         cof_mem[k_ff] <= acc_ff;
      end
      cof_rd_ff <= cof_mem[k_ff];
   end

   always_ff @(posedge clock) begin
      mul_ff <= ma * mb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         load_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff    <= k_in;
      t_ff    <= t_in;
      acc_ff  <= acc_in;
      cof_ff  <= cof_in;
      det_ff  <= det_in;
      lo_ff   <= lo_in;
      sing_ff <= sing_in;
      if (out_load) begin
         value_ff <= sing_ff ? rd0_ff : div_quo;
         pos_ff   <= k_ff;
         rsing_ff <= sing_ff;
         last_ff  <= (k_ff == 4'd15);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = value_ff;
   assign rsp_position = pos_ff;
   assign rsp_singular = rsing_ff;
   assign rsp_last     = last_ff;

endmodule

// ----- hw/rtl/m4i_check.sv -----
// Port checker for the 4x4 matrix inverse, bound to the top level.
module m4i_check (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_value,
   input logic [3:0]  rsp_position,
   input logic        rsp_singular,
   input logic        rsp_last
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value))
      else $error("result item changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("input taken while a run of results is pending");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid || rsp_position == $past(rsp_position) + 4'd1)
      else $error("result position out of order");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last == (rsp_position == 4'd15))
      else $error("last flag does not match position");

   a_sing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> !rsp_valid || rsp_singular == $past(rsp_singular))
      else $error("singular flag changed within a run");

endmodule

bind matrix4_inverse m4i_check u_m4i_check (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_value    (rsp_value),
   .rsp_position (rsp_position),
   .rsp_singular (rsp_singular),
   .rsp_last     (rsp_last)
);

// ----- dv/tb_matrix4_inverse.sv -----
// Testbench for the 4x4 fixed-point matrix inverse: streamed matrices checked against a predictor.
`timescale 1ns / 100ps

module tb_matrix4_inverse
   import m4i_pkg::*;
;

   localparam int F          = 16;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN      = 2000;
   localparam logic [31:0] ONE = 32'h0001_0000;

   typedef struct packed {
      logic [31:0] value;
      logic [3:0]  position;
      logic        singular;
      logic        last;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_element = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_value;
   logic [3:0] rsp_position;
   logic rsp_singular;
   logic rsp_last;

   result_type inverse_q[$];
   logic [31:0] load_buf[16];
   int load_cnt = 0;
   int mismatches = 0;
   int progress = 0;
   int idle = 0;

   logic [31:0] dir_elem[32];
   logic [31:0] dir_value[32];

   matrix4_inverse #(.FRAC_BITS(F)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [255:0] at(input logic [31:0] m[16], input int r,
                                              input int c);
      logic signed [255:0] v;
      v = $signed(m[(c * 4 + r) & 15]);
      return v;
   endfunction

   function automatic logic signed [255:0] cofactor(input logic [31:0] m[16], input int dr,
                                                    input int dc);
      int r[3];
      int c[3];
      int n;
      int i;
      logic signed [255:0] t;
      n = 0;
      for (i = 0; i < 4; i++) if (i != dr) begin r[n] = i; n++; end
      n = 0;
      for (i = 0; i < 4; i++) if (i != dc) begin c[n] = i; n++; end
      t = at(m, r[0], c[0]) * (at(m, r[1], c[1]) * at(m, r[2], c[2])
                              - at(m, r[1], c[2]) * at(m, r[2], c[1]))
        - at(m, r[0], c[1]) * (at(m, r[1], c[0]) * at(m, r[2], c[2])
                              - at(m, r[1], c[2]) * at(m, r[2], c[0]))
        + at(m, r[0], c[2]) * (at(m, r[1], c[0]) * at(m, r[2], c[1])
                              - at(m, r[1], c[1]) * at(m, r[2], c[0]));
      if (((dr + dc) & 1) != 0) t = -t;
      return t;
   endfunction

   task automatic predict_inverse(input logic [31:0] m[16]);
      logic signed [255:0] adj[16];
      logic signed [255:0] det;
      logic signed [255:0] q;
      result_type res;
      int k;
      det = '0;
      for (k = 0; k < 16; k++) adj[k] = cofactor(m, k / 4, k % 4);
      for (k = 0; k < 4; k++) det = det + adj[k * 4] * at(m, k, 0);
      for (k = 0; k < 16; k++) begin
         res.position = 4'(k);
         res.last = (k == 15);
         res.singular = (det == 0);
         if (det == 0) begin
            res.value = m[k];
         end else begin
            q = (adj[k] <<< (2 * F)) / det;
            if (q > $signed(256'sh7FFF_FFFF)) res.value = SAT_MAX;
            else if (q < -$signed(256'sh8000_0000)) res.value = SAT_MIN;
            else res.value = q[31:0];
         end
         inverse_q.push_back(res);
      end
   endtask

   task automatic send_element(input logic [31:0] e, input bit typed, input int row);
      int g;
      logic st;
      result_type res;
      g = pick_gap();
      if (g > 0) begin
         req_valid = 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid = 1'b1;
      req_element = e;
      forever begin
         #1 st = req_stall;
         @(posedge clock);
         if (!st) break;
         @(negedge clock);
      end
      progress++;
      load_buf[load_cnt] = e;
      load_cnt++;
      if (load_cnt == 16) begin
         load_cnt = 0;
         if (typed) begin
            for (int k = 0; k < 16; k++) begin
               res.value = dir_value[row - 15 + k];
               res.position = 4'(k);
               res.singular = 1'b0;
               res.last = (k == 15);
               inverse_q.push_back(res);
            end
         end else begin
            predict_inverse(load_buf);
         end
      end
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_element(input int kind, input int k);
      case (kind)
         0: return $urandom();
         1: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
         2: return (k % 5 == 0) ? ONE * $urandom_range(1, 8)
                                : $signed($urandom_range(0, 1 << 15)) - (1 << 14);
         3: return ($urandom_range(0, 1)) ? SAT_MAX : SAT_MIN;
         default: return $signed($urandom_range(0, 1 << 17)) - (1 << 16);
      endcase
   endfunction

   initial begin
      logic [31:0] m[16];
      int kind;
      for (int k = 0; k < 16; k++) begin
         dir_elem[k] = (k % 5 == 0) ? ONE : '0;
         dir_value[k] = (k % 5 == 0) ? ONE : '0;
         dir_elem[16 + k] = (k % 5 == 0) ? 32'hFFFF_FFFF : '0;
         dir_value[16 + k] = (k % 5 == 0) ? SAT_MIN : '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int i = 0; i < 32; i++) send_element(dir_elem[i], 1'b1, i);
      for (int n = 0; n < 25; n++) begin
         if (n == 8) begin
            req_valid = 1'b0;
            wait (inverse_q.size() == 0);
            @(negedge clock);
         end
         kind = $urandom_range(0, 7);
         for (int k = 0; k < 16; k++) m[k] = rand_element(kind > 4 ? 1 : kind, k);
         if (kind == 5) for (int k = 0; k < 4; k++) m[8 + k] = m[k];
         if (kind == 6) for (int k = 0; k < 16; k++) m[k] = '0;
         if (kind == 7) for (int k = 0; k < 4; k++) m[k * 4 + 3] = m[k * 4 + 1];
         for (int k = 0; k < 16; k++) send_element(m[k], 1'b0, 0);
      end
      req_valid = 1'b0;
      wait (inverse_q.size() == 0);
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      logic v;
      logic st;
      bit calm;
      result_type got;
      result_type want;
      calm = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 199) == 0) calm = !calm;
         st = reset ? 1'b0 : (!calm && pick_gap() > 0);
         rsp_stall = st;
         #1;
         v = rsp_valid;
         got.value = rsp_value;
         got.position = rsp_position;
         got.singular = rsp_singular;
         got.last = rsp_last;
         @(posedge clock);
         if (!reset && v && !st) begin
            progress++;
            if (inverse_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected item: value %h position %0d", got.value, got.position);
            end else begin
               want = inverse_q.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                              want.value, want.position, want.singular, want.last,
                              got.value, got.position, got.singular, got.last);
               end
            end
         end
      end
   end

   initial begin
      int seen;
      seen = 0;
      forever begin
         @(negedge clock);
         if (progress != seen) begin
            seen = progress;
            idle = 0;
         end else if (!reset) begin
            idle++;
            if (idle >= IDLE_LIMIT) begin
               $display("tb: failure");
               $finish;
            end
         end
      end
   end

endmodule

// ----- matrix4_inverse.f -----
hw/rtl/m4i_pkg.sv
hw/rtl/m4i_div.sv
hw/rtl/matrix4_inverse.sv
hw/rtl/m4i_check.sv
dv/tb_matrix4_inverse.sv
